/* sv/fcaod_pkg.sv */
// Shared constants and types for the four-channel average obstacle detector.
`timescale 1ns / 1ps

package fcaod_pkg;

   // Window length and derived widths
   localparam int WINDOW     = 50;
   localparam int NCHAN      = 4;
   localparam int SAMPLE_W   = 12;
   localparam int SLOT_W     = $clog2(WINDOW);
   localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);

   // Division by WINDOW as multiply by rounded-up reciprocal; exact for sums below 2**SUM_W
   localparam int SHIFT      = SUM_W + $clog2(WINDOW);
   localparam int RECIP_W    = SUM_W + 2;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));

   // Stream payload widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   // Channel positions
   localparam int CH_LAT_LEFT    = 0;
   localparam int CH_FRONT_LEFT  = 1;
   localparam int CH_FRONT_RIGHT = 2;
   localparam int CH_LAT_RIGHT   = 3;

   // Register map
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAT_THR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_THR = 2'd1;

   localparam logic [SAMPLE_W-1:0] LAT_THR_RESET   = 12'd1450;
   localparam logic [SAMPLE_W-1:0] FRONT_THR_RESET = 12'd1800;

   typedef logic [SAMPLE_W-1:0]           sample_type;
   typedef sample_type [NCHAN-1:0]        chan_type;
   typedef logic [SUM_W-1:0]              sum_type;
   typedef sum_type [NCHAN-1:0]           sums_type;

endpackage

/* sv/fcaod_window.sv */
// Sample history memory: writes the newest samples over the oldest and returns the evicted ones.
`timescale 1ns / 1ps

module fcaod_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  fcaod_pkg::chan_type wr_samples,
   output fcaod_pkg::chan_type old_samples
);

   fcaod_pkg::chan_type                 mem [fcaod_pkg::WINDOW];
   fcaod_pkg::chan_type                 rd_ff;
   logic                                rd_full_ff;
   logic [fcaod_pkg::SLOT_W-1:0]        slot_ff;
   logic [fcaod_pkg::SLOT_W-1:0]        slot_in;
   logic                                full_ff;
   logic                                full_in;
   logic                                slot_last;

   assign slot_last = (slot_ff == fcaod_pkg::SLOT_W'(fcaod_pkg::WINDOW - 1));

   always_comb begin
      slot_in = slot_ff;
      full_in = full_ff;
      if (wr_en) begin
         if (slot_last) begin
            slot_in = '0;
            full_in = 1'b1;
         end else begin
            slot_in = slot_ff + fcaod_pkg::SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         full_ff <= full_in;
      end
   end

   // read-first: the old entry comes out while the new one goes in
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rd_ff        <= mem[slot_ff];
         rd_full_ff   <= full_ff;
         mem[slot_ff] <= wr_samples;
      end
   end

   // slots not yet written on the first pass count as zero
   assign old_samples = rd_full_ff ? rd_ff : '0;

endmodule

/* sv/four_channel_average_obstacle_detect.sv */
// Top level: four-channel moving-average obstacle detector with stream ports.
//
//   channel  direction  handshake                contents
//   req      in         req_tvalid / req_tready  four samples, detect enable
//   rsp      out        rsp_tvalid / rsp_tready  obstacle flag, four averages
//   csr      in         csr_valid / csr_ready    threshold register writes
//
// One item per cycle sustained while rsp_tready holds high; after the input transfer come
// history read at the transfer edge, then running-sum update, reciprocal multiply and
// compare into output register, after which rsp_tvalid rises.
// Reset clears slot pointer and sums and loads reset thresholds; history entries not yet overwritten
// read as zero through a first-pass flag, so no clearing sweep is needed.
// Each stage is elastic: input keeps flowing into empty stages while a result waits.
`timescale 1ns / 1ps

module four_channel_average_obstacle_detect (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [11:0] lat_left_sample, [23:12] front_left_sample, [35:24] front_right_sample,
   // [47:36] lat_right_sample, [48] detect_enable, [55:49] zero
   input  logic [fcaod_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] obstacle, [12:1] lat_left_avg, [24:13] front_left_avg,
   // [36:25] front_right_avg, [48:37] lat_right_avg, [55:49] zero
   output logic [fcaod_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fcaod_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fcaod_pkg::SAMPLE_W-1:0]       csr_data
);

   // thresholds
   fcaod_pkg::sample_type lat_thr_ff, lat_thr_in;
   fcaod_pkg::sample_type front_thr_ff, front_thr_in;

   // pipeline
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic                  rdy1, rdy2, rdy3, rdy4;
   logic                  req_xfer;
   fcaod_pkg::chan_type   req_samples;
   fcaod_pkg::chan_type   old_samples;
   fcaod_pkg::chan_type   smp1_ff;
   logic                  en1_ff, en2_ff, en3_ff;
   fcaod_pkg::sums_type   sum_ff, sum_in;
   fcaod_pkg::chan_type   avg3_ff, avg3_in;
   fcaod_pkg::chan_type   avg4_ff;
   logic                  obstacle_ff, obstacle_in;
   logic [fcaod_pkg::PROD_W-1:0] prod [fcaod_pkg::NCHAN];

   assign csr_ready = 1'b1;

   always_comb begin
      lat_thr_in   = lat_thr_ff;
      front_thr_in = front_thr_ff;
      if (csr_valid) begin
         case (csr_index)
            fcaod_pkg::CSR_LAT_THR:   lat_thr_in   = csr_data;
            fcaod_pkg::CSR_FRONT_THR: front_thr_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_thr_ff   <= fcaod_pkg::LAT_THR_RESET;
         front_thr_ff <= fcaod_pkg::FRONT_THR_RESET;
      end else begin
         lat_thr_ff   <= lat_thr_in;
         front_thr_ff <= front_thr_in;
      end
   end

   // elastic ready chain from the output back to the input
   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign req_xfer   = req_tvalid && rdy1;

   always_comb begin
      for (int c = 0; c < fcaod_pkg::NCHAN; c++) begin
         req_samples[c] = req_tdata[c*fcaod_pkg::SAMPLE_W +: fcaod_pkg::SAMPLE_W];
      end
   end

   fcaod_window u_window (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (req_xfer),
      .wr_samples  (req_samples),
      .old_samples (old_samples)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // stage 1: new samples wait beside the evicted ones coming out of memory
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         smp1_ff <= req_samples;
         en1_ff  <= req_tdata[fcaod_pkg::NCHAN*fcaod_pkg::SAMPLE_W];
      end
   end

   // stage 2: running sums advance only when a stage-1 item moves on
   always_comb begin
      sum_in = sum_ff;
      if (v1_ff && rdy2) begin
         for (int c = 0; c < fcaod_pkg::NCHAN; c++) begin
            sum_in[c] = sum_ff[c] - fcaod_pkg::SUM_W'(old_samples[c])
                                  + fcaod_pkg::SUM_W'(smp1_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff && rdy2) begin
         en2_ff <= en1_ff;
      end
   end

   // stage 3: divide by the window length
   always_comb begin
      for (int c = 0; c < fcaod_pkg::NCHAN; c++) begin
         prod[c]    = fcaod_pkg::PROD_W'(sum_ff[c]) * fcaod_pkg::PROD_W'(fcaod_pkg::RECIP);
         avg3_in[c] = prod[c][fcaod_pkg::SHIFT +: fcaod_pkg::SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         avg3_ff <= avg3_in;
         en3_ff  <= en2_ff;
      end
   end

   // stage 4: threshold compare into the output register
   assign obstacle_in = en3_ff &&
      ((avg3_ff[fcaod_pkg::CH_LAT_LEFT]    > lat_thr_ff)   ||
       (avg3_ff[fcaod_pkg::CH_LAT_RIGHT]   > lat_thr_ff)   ||
       (avg3_ff[fcaod_pkg::CH_FRONT_LEFT]  > front_thr_ff) ||
       (avg3_ff[fcaod_pkg::CH_FRONT_RIGHT] > front_thr_ff));

   always_ff @(posedge clock) begin
      if (v3_ff && rdy4) begin
         avg4_ff     <= avg3_ff;
         obstacle_ff <= obstacle_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {{(fcaod_pkg::RSP_DATA_W - 1 - fcaod_pkg::NCHAN*fcaod_pkg::SAMPLE_W){1'b0}},
                        avg4_ff, obstacle_ff};

endmodule
